>>> rtl/prime_count_and_sum_in_range_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the prime count and sum core
// Shared property templates, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PRIME_COUNT_AND_SUM_IN_RANGE_CORE_ASSERT_SVH
`define PRIME_COUNT_AND_SUM_IN_RANGE_CORE_ASSERT_SVH

// Same-cycle implication.
`define PCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pcs_pkg.sv
// ----------------------------------------------------------------------------
// Prime count and sum package
// Field widths, result limits and the status bundle shared by the modules.
// ----------------------------------------------------------------------------
package pcs_pkg;

  // Widths of the transaction fields.
  localparam int IN_W    = 16;
  localparam int COUNT_W = 13;
  localparam int SUM_W   = 28;

  // Results saturate at these values.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

  // Smallest prime, also the first trial divisor.
  localparam int FIRST_DIVISOR = 2;

  // Completion status of a multi-cycle unit: a one-cycle done pulse and its
  // single-bit answer.
  typedef struct packed {
    logic done;
    logic flag;
  } pcs_stat_t;

endpackage

>>> rtl/pcs_if.sv
// ----------------------------------------------------------------------------
// Prime count and sum channel interfaces
// Valid/ready channels for the range transaction and the result transaction.
// ----------------------------------------------------------------------------
interface pcs_in_if;
  logic                     valid;
  logic                     ready;
  logic [pcs_pkg::IN_W-1:0] range_low;
  logic [pcs_pkg::IN_W-1:0] range_high;

  modport source (output valid, output range_low, output range_high, input ready);
  modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface pcs_out_if;
  logic                        valid;
  logic                        ready;
  logic [pcs_pkg::COUNT_W-1:0] prime_count;
  logic [pcs_pkg::SUM_W-1:0]   prime_sum;

  modport source (output valid, output prime_count, output prime_sum, input ready);
  modport sink   (input valid, input prime_count, input prime_sum, output ready);
endinterface

>>> rtl/prime_count_and_sum_in_range_core.sv
// ----------------------------------------------------------------------------
// Prime count and sum over a closed range
// Walks every value of the range, tests it by trial division and accumulates
// the number of primes and their sum.
// ----------------------------------------------------------------------------
// One range transaction gives one result transaction. Both bounds are taken
// modulo 2^VALUE_BITS; a lower bound above the upper bound gives zero and
// zero. Otherwise the range walker steps each value through ST_TEST and
// ST_WAIT, and a value of two or more adds a divisor check and a trial
// division per divisor tried. A prime v tries every divisor from 2 to
// floor(sqrt(v)). The run time is set by the single bit-serial remainder
// unit, which resolves one dividend bit per cycle and serves the whole
// range in turn. A new range is taken once the previous result sits in the
// output register; a result not yet taken holds the next one back. The
// count saturates at 8191 and the sum at 2^28 - 1, which only larger
// VALUE_BITS can reach.
module prime_count_and_sum_in_range_core #(
  parameter int VALUE_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pcs_in_if.sink    in_ch,
  pcs_out_if.source out_ch
);

  localparam int W = VALUE_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_WAIT,
    ST_FINISH
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [pcs_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [pcs_pkg::SUM_W-1:0]   out_sum_r, out_sum_nxt;
  logic [W-1:0]                val_r, val_nxt;
  logic [W-1:0]                hi_r, hi_nxt;
  logic [pcs_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [pcs_pkg::SUM_W-1:0]   sum_r, sum_nxt;

  logic [W-1:0]                lo_w;
  logic [W-1:0]                hi_w;
  logic [pcs_pkg::SUM_W:0]     sum_add;
  logic                        test_start;
  pcs_pkg::pcs_stat_t          test_stat;

  // Bounds reduced to the value width.
  assign lo_w = W'(in_ch.range_low);
  assign hi_w = W'(in_ch.range_high);

  assign sum_add    = {1'b0, sum_r} + (pcs_pkg::SUM_W + 1)'(val_r);
  assign test_start = (state_r == ST_TEST);

  pcs_prime_test #(
    .W (W)
  ) u_test (
    .clk   (clk),
    .rst_n (rst_n),
    .start (test_start),
    .value (val_r),
    .stat  (test_stat)
  );

  // Range walker and output register.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_sum_nxt   = out_sum_r;
    val_nxt       = val_r;
    hi_nxt        = hi_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          val_nxt   = lo_w;
          hi_nxt    = hi_w;
          count_nxt = '0;
          sum_nxt   = '0;
          state_nxt = (lo_w > hi_w) ? ST_FINISH : ST_TEST;
        end
      end
      ST_TEST: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (test_stat.done) begin
          if (test_stat.flag) begin
            if (count_r != pcs_pkg::COUNT_MAX) begin
              count_nxt = count_r + 1'b1;
            end
            sum_nxt = sum_add[pcs_pkg::SUM_W] ? pcs_pkg::SUM_MAX
                                               : sum_add[pcs_pkg::SUM_W-1:0];
          end
          // The upper bound may be the largest value, so stop before stepping.
          if (val_r == hi_r) begin
            state_nxt = ST_FINISH;
          end else begin
            val_nxt   = val_r + 1'b1;
            state_nxt = ST_TEST;
          end
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          out_sum_nxt   = sum_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_count_r <= out_count_nxt;
    out_sum_r   <= out_sum_nxt;
    val_r       <= val_nxt;
    hi_r        <= hi_nxt;
    count_r     <= count_nxt;
    sum_r       <= sum_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.prime_count = out_count_r;
  assign out_ch.prime_sum   = out_sum_r;

endmodule

>>> rtl/pcs_rem_serial.sv
// ----------------------------------------------------------------------------
// Bit-serial remainder unit
// Restoring division, one dividend bit per cycle; reports whether the
// remainder is zero.
// ----------------------------------------------------------------------------
module pcs_rem_serial #(
  parameter int W = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  output pcs_pkg::pcs_stat_t stat
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             zero_r, zero_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     dvd_r, dvd_nxt;
  logic [W-1:0]     dsr_r, dsr_nxt;

  logic [W:0]       trial;
  logic [W:0]       diff;
  logic [W-1:0]     rem_step;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    trial    = {rem_r, dvd_r[W-1]};
    diff     = trial - {1'b0, dsr_r};
    rem_step = (trial >= {1'b0, dsr_r}) ? diff[W-1:0] : trial[W-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    if (busy_r) begin
      rem_nxt = rem_step;
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        zero_nxt = (rem_step == '0);
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(W);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    zero_r <= zero_nxt;
    rem_r  <= rem_nxt;
    dvd_r  <= dvd_nxt;
    dsr_r  <= dsr_nxt;
  end

  assign stat.done = done_r;
  assign stat.flag = zero_r;

endmodule

>>> rtl/pcs_prime_test.sv
// ----------------------------------------------------------------------------
// Trial-division primality tester
// Steps divisors from two while the divisor squared stays within the value
// and runs each division on the bit-serial remainder unit.
// ----------------------------------------------------------------------------
module pcs_prime_test #(
  parameter int W = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [W-1:0]       value,
  output pcs_pkg::pcs_stat_t stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV
  } state_t;

  localparam logic [W-1:0] FIRST_D  = W'(pcs_pkg::FIRST_DIVISOR);
  localparam logic [W:0]   FIRST_SQ =
    (W + 1)'(pcs_pkg::FIRST_DIVISOR * pcs_pkg::FIRST_DIVISOR);

  state_t       state_r, state_nxt;
  logic         done_r, done_nxt;
  logic         prime_r, prime_nxt;
  logic [W-1:0] val_r, val_nxt;
  logic [W-1:0] d_r, d_nxt;
  logic [W:0]   sq_r, sq_nxt;

  logic               sq_over;
  logic               div_start;
  pcs_pkg::pcs_stat_t div_stat;

  // Once the divisor squared passes the value, no factor is left to find.
  assign sq_over   = (sq_r > {1'b0, val_r});
  assign div_start = (state_r == ST_CHECK) && !sq_over;

  pcs_rem_serial #(
    .W (W)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (val_r),
    .divisor  (d_r),
    .stat     (div_stat)
  );

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    prime_nxt = prime_r;
    val_nxt   = val_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          val_nxt = value;
          d_nxt   = FIRST_D;
          sq_nxt  = FIRST_SQ;
          // Zero and one are not prime.
          if (value < FIRST_D) begin
            done_nxt  = 1'b1;
            prime_nxt = 1'b0;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sq_over) begin
          done_nxt  = 1'b1;
          prime_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (div_stat.flag) begin
            done_nxt  = 1'b1;
            prime_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            // (d+1)^2 = d^2 + 2d + 1
            d_nxt     = d_r + 1'b1;
            sq_nxt    = sq_r + {d_r, 1'b0} + 1'b1;
            state_nxt = ST_CHECK;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    prime_r <= prime_nxt;
    val_r   <= val_nxt;
    d_r     <= d_nxt;
    sq_r    <= sq_nxt;
  end

  assign stat.done = done_r;
  assign stat.flag = prime_r;

endmodule

>>> rtl/pcs_checker.sv
// ----------------------------------------------------------------------------
// Port checker for the prime count and sum core
// Watches the channel ports and checks result consistency and timing.
// ----------------------------------------------------------------------------
`include "prime_count_and_sum_in_range_core_assert.svh"

module pcs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pcs_pkg::COUNT_W-1:0] out_count,
  input logic [pcs_pkg::SUM_W-1:0]   out_sum
);

  // A stalled result transaction stays offered.
  `PCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // No primes means no sum, and any prime gives a nonzero sum.
  `PCS_ASSERT_NOW(a_zero_match, out_valid, (out_count == '0) == (out_sum == '0), "count and sum disagree on empty")

  // Every prime is at least two, so the sum is at least twice the count.
  `PCS_ASSERT_NOW(a_sum_bound, out_valid, {1'b0, out_sum} >= {15'd0, out_count, 1'b0}, "sum below twice the count")

  // A result never appears in the cycle right after a range is taken.
  `PCS_ASSERT_NEXT(a_min_latency, in_valid && in_ready, !$rose(out_valid), "result too early")

endmodule

bind prime_count_and_sum_in_range_core pcs_checker u_pcs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_count (out_ch.prime_count),
  .out_sum   (out_ch.prime_sum)
);

>>> verif/prime_count_and_sum_in_range_core_tb.sv
// ----------------------------------------------------------------------------
// Prime count and sum core testbench
// Sends range transactions through the valid/ready input channel and checks
// every result transaction against a sieve-based predictor. The run covers
// directed edge ranges, random bursts under two receiver stall patterns,
// back-to-back streaming, and a long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module prime_count_and_sum_in_range_core_tb;

  localparam int          VALUE_BITS   = 16;
  localparam int unsigned TABLE_SIZE   = 1 << VALUE_BITS;
  localparam int unsigned VALUE_MASK   = TABLE_SIZE - 1;
  localparam int unsigned CYCLE_LIMIT  = 6_000_000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // Receiver stall styles.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_style_t;

  // One expected result transaction.
  typedef struct packed {
    logic [pcs_pkg::COUNT_W-1:0] count;
    logic [pcs_pkg::SUM_W-1:0]   sum;
  } prime_totals_t;

  logic clk = 1'b0;
  logic rst_n;

  pcs_in_if  in_if ();
  pcs_out_if out_if ();

  prime_count_and_sum_in_range_core #(
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if)
  );

  // Composite flags for every value of the bound range; 0 and 1 are flagged.
  bit            not_prime [0:TABLE_SIZE-1];
  prime_totals_t expected_totals[$];

  rx_style_t   rx_style      = RX_ALWAYS;
  int unsigned rx_phase      = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;
  int unsigned burst_left    = 0;
  int unsigned cycle_count   = 0;
  int unsigned error_count   = 0;
  int unsigned ranges_sent   = 0;
  int unsigned results_seen  = 0;
  int unsigned empty_ranges  = 0;
  int unsigned widest_range  = 0;

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Expected count and sum of the primes in [lo, hi], bounds wrapped to
  // VALUE_BITS and the totals clamped at the result limits.
  function automatic prime_totals_t range_prime_totals(
    input logic [pcs_pkg::IN_W-1:0] lo_in,
    input logic [pcs_pkg::IN_W-1:0] hi_in);
    int unsigned     lo;
    int unsigned     hi;
    longint unsigned n_primes;
    longint unsigned total;
    prime_totals_t   r;
    lo       = int'(lo_in) & VALUE_MASK;
    hi       = int'(hi_in) & VALUE_MASK;
    n_primes = 0;
    total    = 0;
    if (lo <= hi) begin
      for (int unsigned v = lo; v <= hi; v++) begin
        if (!not_prime[v]) begin
          n_primes++;
          total += v;
        end
      end
    end
    if (n_primes > pcs_pkg::COUNT_MAX) n_primes = pcs_pkg::COUNT_MAX;
    if (total > pcs_pkg::SUM_MAX) total = pcs_pkg::SUM_MAX;
    r.count = n_primes[pcs_pkg::COUNT_W-1:0];
    r.sum   = total[pcs_pkg::SUM_W-1:0];
    return r;
  endfunction

  // Offer one range and wait until the block takes it; the expectation is
  // recorded at the accepting edge.
  task automatic send_range(input logic [pcs_pkg::IN_W-1:0] lo,
                            input logic [pcs_pkg::IN_W-1:0] hi);
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.range_low  <= lo;
    in_if.range_high <= hi;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_totals.push_back(range_prime_totals(lo, hi));
    ranges_sent++;
    if (lo > hi) empty_ranges++;
    else if (int'(hi) - int'(lo) + 1 > widest_range) widest_range = int'(hi) - int'(lo) + 1;
  endtask

  task automatic idle_sender(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
  endtask

  // Bursts of random length separated by random gaps.
  task automatic pace_sender();
    if (burst_left == 0) begin
      idle_sender($urandom_range(0, 6));
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  task automatic wait_for_results();
    while (expected_totals.size() != 0) @(posedge clk);
  endtask

  // Random range: mostly short spans anywhere in the value range, some wider
  // spans among the low values, some at the very top, some empty.
  function automatic void pick_range(output logic [pcs_pkg::IN_W-1:0] lo,
                                     output logic [pcs_pkg::IN_W-1:0] hi);
    int unsigned kind;
    int unsigned base;
    int unsigned span;
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      base = $urandom_range(1, TABLE_SIZE - 1);
      lo   = base[pcs_pkg::IN_W-1:0];
      hi   = (pcs_pkg::IN_W)'($urandom_range(0, base - 1));
    end else if (kind < 4) begin
      base = $urandom_range(0, 4000);
      span = $urandom_range(8, 64);
      lo   = base[pcs_pkg::IN_W-1:0];
      hi   = (pcs_pkg::IN_W)'(base + span);
    end else if (kind < 5) begin
      span = $urandom_range(0, 6);
      lo   = (pcs_pkg::IN_W)'(TABLE_SIZE - 1 - span);
      hi   = (pcs_pkg::IN_W)'(TABLE_SIZE - 1);
    end else begin
      base = $urandom_range(0, TABLE_SIZE - 1);
      span = $urandom_range(0, 6);
      lo   = base[pcs_pkg::IN_W-1:0];
      hi   = (base + span > TABLE_SIZE - 1) ? (pcs_pkg::IN_W)'(TABLE_SIZE - 1)
                                            : (pcs_pkg::IN_W)'(base + span);
    end
  endfunction

  // Receiver: a requested hold-off wins, otherwise the current stall style.
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left--;
    end else begin
      case (rx_style)
        RX_ALWAYS:  out_if.ready <= 1'b1;
        RX_RANDOM:  out_if.ready <= ($urandom_range(0, 99) < 65);
        RX_PATTERN: out_if.ready <= ((rx_phase % 7) >= 2);
        default:    out_if.ready <= 1'b1;
      endcase
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_totals.size() == 0) begin
        $display("%0t: unexpected result count=%0d sum=%0d", $time,
                 out_if.prime_count, out_if.prime_sum);
        error_count++;
      end else begin
        if (out_if.prime_count !== expected_totals[0].count) begin
          $display("%0t: prime_count expected %0d, actual %0d", $time,
                   expected_totals[0].count, out_if.prime_count);
          error_count++;
        end
        if (out_if.prime_sum !== expected_totals[0].sum) begin
          $display("%0t: prime_sum expected %0d, actual %0d", $time,
                   expected_totals[0].sum, out_if.prime_sum);
          error_count++;
        end
        void'(expected_totals.pop_front());
        results_seen++;
      end
    end
  end

  // Edge ranges: single values, primes at both ends, empty ranges, the top
  // of the value range and alternating bit patterns.
  task automatic test_edge_ranges();
    rx_style = RX_ALWAYS;
    send_range(16'd0, 16'd0);
    send_range(16'd1, 16'd1);
    send_range(16'd2, 16'd2);
    send_range(16'd0, 16'd1);
    send_range(16'd0, 16'd2);
    send_range(16'd3, 16'd4);
    send_range(16'd4, 16'd4);
    send_range(16'd0, 16'd500);
    send_range(16'd65521, 16'd65521);
    send_range(16'd65521, 16'd65535);
    send_range(16'd65534, 16'd65535);
    send_range(16'd65535, 16'd65535);
    send_range(16'd65535, 16'd0);
    send_range(16'd1, 16'd0);
    send_range(16'd100, 16'd50);
    send_range(16'h5555, 16'h555A);
    send_range(16'hAAAA, 16'hAAB0);
    send_range(16'h8000, 16'h7FFF);
    idle_sender(1);
    wait_for_results();
  endtask

  // Random ranges in bursts under a random and then a periodic receiver.
  task automatic test_random_bursts();
    logic [pcs_pkg::IN_W-1:0] lo;
    logic [pcs_pkg::IN_W-1:0] hi;
    rx_style = RX_RANDOM;
    repeat (45) begin
      pick_range(lo, hi);
      send_range(lo, hi);
      pace_sender();
    end
    rx_style = RX_PATTERN;
    repeat (18) begin
      pick_range(lo, hi);
      send_range(lo, hi);
      pace_sender();
    end
    idle_sender(1);
  endtask

  // Back-to-back ranges with no idling on either side.
  task automatic test_streaming();
    logic [pcs_pkg::IN_W-1:0] lo;
    logic [pcs_pkg::IN_W-1:0] hi;
    wait_for_results();
    rx_style = RX_ALWAYS;
    repeat (15) begin
      pick_range(lo, hi);
      send_range(lo, hi);
    end
    idle_sender(1);
  endtask

  // Long output hold-off while cheap ranges keep coming, so the block backs
  // up and stalls its input.
  task automatic test_output_backpressure();
    int unsigned base;
    wait_for_results();
    rx_style     = RX_ALWAYS;
    hold_request = 3000;
    repeat (8) begin
      base = $urandom_range(0, 30);
      send_range((pcs_pkg::IN_W)'(base), (pcs_pkg::IN_W)'(base + $urandom_range(0, 3)));
    end
    idle_sender(1);
    wait_for_results();
  endtask

  initial begin
    int unsigned d;
    int unsigned k;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.range_low  = '0;
    in_if.range_high = '0;
    out_if.ready     = 1'b0;

    // Sieve of the whole bound range.
    not_prime[0] = 1'b1;
    not_prime[1] = 1'b1;
    for (d = 2; d * d < TABLE_SIZE; d++) begin
      if (!not_prime[d]) begin
        for (k = d * d; k < TABLE_SIZE; k += d) not_prime[k] = 1'b1;
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_ranges();
    test_output_backpressure();
    test_random_bursts();
    test_streaming();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d ranges (%0d empty, widest span %0d values).",
             results_seen, ranges_sent, empty_ranges, widest_range);
    $display("Receiver styles: always ready, random, periodic, plus one 3000-cycle hold-off.");
    if (error_count == 0 && expected_totals.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0t: %0d mismatches, %0d results outstanding", $time, error_count,
               expected_totals.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/pcs_pkg.sv
rtl/pcs_if.sv
rtl/pcs_rem_serial.sv
rtl/pcs_prime_test.sv
rtl/prime_count_and_sum_in_range_core.sv
rtl/pcs_checker.sv
verif/prime_count_and_sum_in_range_core_tb.sv
